// ===== hw/rtl/cnsd_pkg.sv =====
`timescale 1ns / 1ps

package cnsd_pkg;

    // Request function codes
    localparam logic [1:0] FUNC_FRAME = 2'd0;
    localparam logic [1:0] FUNC_HOME  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Node number width (low bits of the CAN identifier)
    localparam int NODE_W = 7;

    // Function code of the identifier, bits 10:7
    localparam logic [3:0] KIND_SDO_RESP = 4'hB;   // 0x580
    localparam logic [3:0] KIND_TPDO1    = 4'h3;   // 0x180

    // SDO object indexes
    localparam logic [15:0] OBJ_ENCODER  = 16'h6064;
    localparam logic [15:0] OBJ_STATUS   = 16'h6041;
    localparam logic [15:0] OBJ_CURRENT  = 16'h2027;
    localparam logic [15:0] OBJ_VELOCITY = 16'h606C;
    localparam logic [15:0] OBJ_DEMAND   = 16'h2031;
    localparam logic [15:0] OBJ_MODE     = 16'h6061;
    localparam logic [15:0] OBJ_ANALOG   = 16'h207C;

    localparam logic [7:0] SUB_MAIN   = 8'd0;
    localparam logic [7:0] SUB_ANALOG = 8'd1;

    // Update mask bits
    localparam logic [6:0] MASK_NONE     = 7'h00;
    localparam logic [6:0] MASK_ENCODER  = 7'h01;
    localparam logic [6:0] MASK_STATUS   = 7'h02;
    localparam logic [6:0] MASK_CURRENT  = 7'h04;
    localparam logic [6:0] MASK_VELOCITY = 7'h08;
    localparam logic [6:0] MASK_DEMAND   = 7'h10;
    localparam logic [6:0] MASK_MODE     = 7'h20;
    localparam logic [6:0] MASK_ANALOG   = 7'h40;
    localparam logic [6:0] MASK_TPDO1    = 7'h07;

endpackage

// ===== hw/rtl/canopen_node_status_decoder_core.sv =====
`timescale 1ns / 1ps

// CANopen node status decoder.
// Input channel (item_valid / item_stall) carries one request: a received
// CAN frame (func 0), a home-offset capture for all nodes (func 1) or a
// node read (func 2). Output channel (result_valid / result_stall) returns
// exactly one result per request, in order.
// A request is taken into an input register. As it leaves that register the
// frame is decoded, the node tables are updated and the result register is
// loaded; result_valid is driven by the result register.
// Throughput is one request per cycle: the input register drains whenever
// the result register is empty or being taken.
// When the receiver stalls, the result register holds its value and the
// input register keeps one more request; item_stall rises only when both
// are full.
// Reset clears both valid flags, all node tables and the homing flag.
// Node tables are flip-flop arrays of NODE_COUNT entries, read at entry node - 1
// for the node in the input register; a home capture copies all encoder entries.
module canopen_node_status_decoder_core #(
    parameter int NODE_COUNT = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [1:0]          func,
    input  logic [10:0]         frame_id,
    input  logic [63:0]         frame_bytes,
    input  logic [3:0]          node_select,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [10:0]         id_echo,
    output logic [6:0]          node_number,
    output logic                node_accepted,
    output logic [6:0]          updated_mask,
    output logic signed [32:0]  position,
    output logic [15:0]         status_word,
    output logic signed [31:0]  velocity,
    output logic signed [15:0]  motor_current,
    output logic signed [31:0]  demand_current,
    output logic signed [7:0]   mode_display,
    output logic signed [15:0]  analog_in
);

    localparam int SLOT_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int NW     = cnsd_pkg::NODE_W;

    // Input register
    logic         s1_valid_reg, s1_valid_next;
    logic [1:0]   s1_func_reg;
    logic [10:0]  s1_id_reg;
    logic [63:0]  s1_bytes_reg;
    logic [3:0]   s1_sel_reg;

    // Node tables
    logic [31:0]  enc_table_reg      [NODE_COUNT];
    logic [31:0]  home_table_reg     [NODE_COUNT];
    logic [15:0]  status_table_reg   [NODE_COUNT];
    logic [15:0]  current_table_reg  [NODE_COUNT];
    logic [31:0]  velocity_table_reg [NODE_COUNT];
    logic [31:0]  demand_table_reg   [NODE_COUNT];
    logic [7:0]   mode_table_reg     [NODE_COUNT];
    logic [15:0]  analog_table_reg   [NODE_COUNT];
    logic         homing_done_reg;

    // Result register
    logic         result_valid_reg, result_valid_next;
    logic [10:0]  id_echo_reg;
    logic [6:0]   node_number_reg;
    logic         node_accepted_reg;
    logic [6:0]   updated_mask_reg;
    logic [32:0]  position_reg;
    logic [15:0]  status_word_reg;
    logic [31:0]  velocity_reg;
    logic [15:0]  motor_current_reg;
    logic [31:0]  demand_current_reg;
    logic [7:0]   mode_display_reg;
    logic [15:0]  analog_in_reg;

    // Decode signals
    logic              accept;
    logic              advance;
    logic              is_frame, is_home, is_read;
    logic [NW-1:0]     node;
    logic [NW-1:0]     node_m1;
    logic              node_ok;
    logic [SLOT_W-1:0] slot;
    logic              kind_sdo, kind_tpdo;
    logic [15:0]       sdo_index;
    logic [7:0]        sdo_sub;
    logic [31:0]       hi_word;
    logic [6:0]        mask;
    logic [31:0]       enc_wdata;
    logic [15:0]       status_wdata, current_wdata;
    logic [31:0]       enc_rd, velocity_rd, demand_rd;
    logic [15:0]       status_rd, current_rd, analog_rd;
    logic [7:0]        mode_rd;
    logic [32:0]       home_ext;
    logic [32:0]       pos_val;

    // Handshake
    assign advance      = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall   = s1_valid_reg && !advance;
    assign accept       = item_valid && !item_stall;
    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign result_valid_next = advance ? 1'b1 : (result_stall ? result_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Input payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg  <= func;
            s1_id_reg    <= frame_id;
            s1_bytes_reg <= frame_bytes;
            s1_sel_reg   <= node_select;
        end
    end

    // Request and node decode
    always_comb
    begin
        is_frame = (s1_func_reg == cnsd_pkg::FUNC_FRAME);
        is_home  = (s1_func_reg == cnsd_pkg::FUNC_HOME);
        is_read  = (s1_func_reg == cnsd_pkg::FUNC_READ);
        if (is_frame)
            node = s1_id_reg[NW-1:0];
        else if (is_read)
            node = {{(NW-4){1'b0}}, s1_sel_reg};
        else
            node = '0;
        node_ok = (is_frame || is_read) && (node != '0) &&
                  (node <= NW'(NODE_COUNT));
        node_m1 = node - NW'(1);
        slot    = node_m1[SLOT_W-1:0];
    end

    // Frame decode: SDO response or TPDO1
    always_comb
    begin
        kind_sdo  = (s1_id_reg[10:7] == cnsd_pkg::KIND_SDO_RESP);
        kind_tpdo = (s1_id_reg[10:7] == cnsd_pkg::KIND_TPDO1);
        sdo_index = s1_bytes_reg[23:8];
        sdo_sub   = s1_bytes_reg[31:24];
        hi_word   = s1_bytes_reg[63:32];
        mask      = cnsd_pkg::MASK_NONE;
        if (is_frame && node_ok)
        begin
            if (kind_sdo)
            begin
                unique case (sdo_index)
                    cnsd_pkg::OBJ_ENCODER:
                        if (sdo_sub == cnsd_pkg::SUB_MAIN) mask = cnsd_pkg::MASK_ENCODER;
                    cnsd_pkg::OBJ_STATUS:
                        if (sdo_sub == cnsd_pkg::SUB_MAIN) mask = cnsd_pkg::MASK_STATUS;
                    cnsd_pkg::OBJ_CURRENT:
                        if (sdo_sub == cnsd_pkg::SUB_MAIN) mask = cnsd_pkg::MASK_CURRENT;
                    cnsd_pkg::OBJ_VELOCITY:
                        if (sdo_sub == cnsd_pkg::SUB_MAIN) mask = cnsd_pkg::MASK_VELOCITY;
                    cnsd_pkg::OBJ_DEMAND:
                        if (sdo_sub == cnsd_pkg::SUB_MAIN) mask = cnsd_pkg::MASK_DEMAND;
                    cnsd_pkg::OBJ_MODE:
                        if (sdo_sub == cnsd_pkg::SUB_MAIN) mask = cnsd_pkg::MASK_MODE;
                    cnsd_pkg::OBJ_ANALOG:
                        if (sdo_sub == cnsd_pkg::SUB_ANALOG) mask = cnsd_pkg::MASK_ANALOG;
                    default:
                        mask = cnsd_pkg::MASK_NONE;
                endcase
            end
            else if (kind_tpdo)
            begin
                mask = cnsd_pkg::MASK_TPDO1;
            end
        end
        // TPDO1 packs encoder, current and status; SDO carries one value in bytes 4..7
        enc_wdata     = kind_tpdo ? s1_bytes_reg[31:0]  : hi_word;
        current_wdata = kind_tpdo ? s1_bytes_reg[47:32] : hi_word[15:0];
        status_wdata  = kind_tpdo ? s1_bytes_reg[63:48] : hi_word[15:0];
    end

    // Table read, bypassing this request's own write
    always_comb
    begin
        enc_rd      = mask[0] ? enc_wdata      : enc_table_reg[slot];
        status_rd   = mask[1] ? status_wdata   : status_table_reg[slot];
        current_rd  = mask[2] ? current_wdata  : current_table_reg[slot];
        velocity_rd = mask[3] ? hi_word        : velocity_table_reg[slot];
        demand_rd   = mask[4] ? hi_word        : demand_table_reg[slot];
        mode_rd     = mask[5] ? hi_word[7:0]   : mode_table_reg[slot];
        analog_rd   = mask[6] ? hi_word[15:0]  : analog_table_reg[slot];
        home_ext    = homing_done_reg ?
                      {home_table_reg[slot][31], home_table_reg[slot]} : 33'd0;
        pos_val     = {enc_rd[31], enc_rd} - home_ext;
    end

    // Table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            homing_done_reg <= 1'b0;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                enc_table_reg[i]      <= '0;
                home_table_reg[i]     <= '0;
                status_table_reg[i]   <= '0;
                current_table_reg[i]  <= '0;
                velocity_table_reg[i] <= '0;
                demand_table_reg[i]   <= '0;
                mode_table_reg[i]     <= '0;
                analog_table_reg[i]   <= '0;
            end
        end
        else if (advance)
        begin
            if (is_home)
            begin
                homing_done_reg <= 1'b1;
                for (int i = 0; i < NODE_COUNT; i++)
                    home_table_reg[i] <= enc_table_reg[i];
            end
            if (mask[0]) enc_table_reg[slot]      <= enc_wdata;
            if (mask[1]) status_table_reg[slot]   <= status_wdata;
            if (mask[2]) current_table_reg[slot]  <= current_wdata;
            if (mask[3]) velocity_table_reg[slot] <= hi_word;
            if (mask[4]) demand_table_reg[slot]   <= hi_word;
            if (mask[5]) mode_table_reg[slot]     <= hi_word[7:0];
            if (mask[6]) analog_table_reg[slot]   <= hi_word[15:0];
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            id_echo_reg        <= is_frame ? s1_id_reg : 11'd0;
            node_number_reg    <= node;
            node_accepted_reg  <= node_ok;
            updated_mask_reg   <= mask;
            position_reg       <= node_ok ? pos_val     : '0;
            status_word_reg    <= node_ok ? status_rd   : '0;
            velocity_reg       <= node_ok ? velocity_rd : '0;
            motor_current_reg  <= node_ok ? current_rd  : '0;
            demand_current_reg <= node_ok ? demand_rd   : '0;
            mode_display_reg   <= node_ok ? mode_rd     : '0;
            analog_in_reg      <= node_ok ? analog_rd   : '0;
        end
    end

    assign result_valid   = result_valid_reg;
    assign id_echo        = id_echo_reg;
    assign node_number    = node_number_reg;
    assign node_accepted  = node_accepted_reg;
    assign updated_mask   = updated_mask_reg;
    assign position       = $signed(position_reg);
    assign status_word    = status_word_reg;
    assign velocity       = $signed(velocity_reg);
    assign motor_current  = $signed(motor_current_reg);
    assign demand_current = $signed(demand_current_reg);
    assign mode_display   = $signed(mode_display_reg);
    assign analog_in      = $signed(analog_in_reg);

endmodule

// ===== hw/rtl/cnsd_checker.sv =====
`timescale 1ns / 1ps

module cnsd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input logic [10:0]         id_echo,
    input logic [6:0]          node_number,
    input logic                node_accepted,
    input logic [6:0]          updated_mask,
    input logic signed [32:0]  position,
    input logic [15:0]         status_word
);

    // A stalled result holds
    property p_result_hold;
        @(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(id_echo) && $stable(updated_mask) &&
            $stable(position) && $stable(node_number);
    endproperty
    a_result_hold: assert property (p_result_hold)
        else $error("result changed while stalled");

    // Input is held off only while a stalled result blocks the pipe
    property p_input_stall;
        @(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |-> result_valid && result_stall;
    endproperty
    a_input_stall: assert property (p_input_stall)
        else $error("input stalled with room in the pipe");

    // Rejected node reports no update and no data
    property p_reject_zero;
        @(posedge clk) disable iff (!rst_n)
        result_valid && !node_accepted |->
            updated_mask == cnsd_pkg::MASK_NONE && position == '0 &&
            status_word == '0;
    endproperty
    a_reject_zero: assert property (p_reject_zero)
        else $error("rejected node reported data");

    // Updates come only from SDO responses or TPDO1 frames
    property p_update_source;
        @(posedge clk) disable iff (!rst_n)
        result_valid && updated_mask != cnsd_pkg::MASK_NONE |->
            node_accepted &&
            (id_echo[10:7] == cnsd_pkg::KIND_SDO_RESP ||
             id_echo[10:7] == cnsd_pkg::KIND_TPDO1);
    endproperty
    a_update_source: assert property (p_update_source)
        else $error("update from unexpected frame");

    // SDO writes one object, TPDO1 writes its fixed group
    property p_mask_shape;
        @(posedge clk) disable iff (!rst_n)
        result_valid |->
            (id_echo[10:7] == cnsd_pkg::KIND_TPDO1 && node_accepted) ?
                updated_mask == cnsd_pkg::MASK_TPDO1 : $onehot0(updated_mask);
    endproperty
    a_mask_shape: assert property (p_mask_shape)
        else $error("bad update mask");

endmodule

bind canopen_node_status_decoder_core cnsd_checker u_cnsd_checker (.*);
